// ===== rtl/core/ddq_pkg.sv =====
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared sizes, codes, microcode word layout and the control store of the
// deque with delete by value.
// ----------------------------------------------------------------------------
`default_nettype none

package ddq_pkg;

   localparam int DEPTH  = 16;
   localparam int AddrW  = $clog2(DEPTH);
   localparam int CntW   = $clog2(DEPTH + 1);
   localparam int SumW   = $clog2(2 * DEPTH + 1);
   localparam int DataW  = 32;
   localparam int FuncW  = 3;
   localparam int StatW  = 2;
   localparam int PcW    = 4;

   // request codes
   localparam logic [FuncW-1:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [FuncW-1:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [FuncW-1:0] FN_POP_FRONT  = 3'd2;
   localparam logic [FuncW-1:0] FN_POP_BACK   = 3'd3;
   localparam logic [FuncW-1:0] FN_DELETE     = 3'd4;

   // status codes
   localparam logic [StatW-1:0] ST_DONE = 2'd0;
   localparam logic [StatW-1:0] ST_MISS = 2'd1;
   localparam logic [StatW-1:0] ST_FULL = 2'd2;

   // control store addresses
   localparam logic [PcW-1:0] PC_PUSH_F     = 4'd0;
   localparam logic [PcW-1:0] PC_PUSH_F_WR  = 4'd1;
   localparam logic [PcW-1:0] PC_PUSH_B     = 4'd2;
   localparam logic [PcW-1:0] PC_PUSH_B_WR  = 4'd3;
   localparam logic [PcW-1:0] PC_POP_F      = 4'd4;
   localparam logic [PcW-1:0] PC_POP_F_UPD  = 4'd5;
   localparam logic [PcW-1:0] PC_POP_B      = 4'd6;
   localparam logic [PcW-1:0] PC_POP_B_UPD  = 4'd7;
   localparam logic [PcW-1:0] PC_SCAN_RD    = 4'd8;
   localparam logic [PcW-1:0] PC_SCAN_CMP   = 4'd9;
   localparam logic [PcW-1:0] PC_SHIFT_RD   = 4'd10;
   localparam logic [PcW-1:0] PC_SHIFT_WR   = 4'd11;
   localparam logic [PcW-1:0] PC_DEL        = 4'd12;
   localparam logic [PcW-1:0] PC_REFUSE     = 4'd13;
   localparam logic [PcW-1:0] PC_MISS       = 4'd14;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_FULL,
      COND_EMPTY,
      COND_KEND,
      COND_K1END,
      COND_NOMATCH
   } cond_type;

   typedef enum logic [0:0] { RA_K, RA_K1 } rd_sel_type;
   typedef enum logic [1:0] { WA_FRONT_M1, WA_BACK, WA_K } wr_sel_type;
   typedef enum logic [0:0] { WD_VALUE, WD_RDATA } wd_sel_type;
   typedef enum logic [1:0] { K_HOLD, K_INC, K_INC_TK } k_op_type;
   typedef enum logic [1:0] { CNT_HOLD, CNT_INC, CNT_DEC } cnt_op_type;
   typedef enum logic [1:0] { FR_HOLD, FR_INC, FR_DEC } front_op_type;

   typedef struct packed {
      cond_type         cond;
      logic [PcW-1:0]   target;
      rd_sel_type       ra;
      logic             we;
      wr_sel_type       wa;
      wd_sel_type       wd;
      k_op_type         k_op;
      cnt_op_type       cnt_op;
      front_op_type     front_op;
      logic [StatW-1:0] status;
      logic             last;
   } uword_type;

   localparam uword_type UW_NOP = '{
      cond: COND_NEXT, target: PC_MISS, ra: RA_K, we: 1'b0, wa: WA_K,
      wd: WD_VALUE, k_op: K_HOLD, cnt_op: CNT_HOLD, front_op: FR_HOLD,
      status: ST_DONE, last: 1'b0
   };

   // ring position of an offset from the front entry
   function automatic logic [AddrW-1:0] ring_pos(input logic [AddrW-1:0] front,
                                                 input logic [CntW-1:0]  off);
      logic [SumW-1:0] sum;
      sum = SumW'(front) + SumW'(off);
      if (sum >= SumW'(DEPTH)) begin
         sum = sum - SumW'(DEPTH);
      end
      return sum[AddrW-1:0];
   endfunction

   function automatic logic [PcW-1:0] entry_pc(input logic [FuncW-1:0] func);
      logic [PcW-1:0] pc;
      case (func)
         FN_PUSH_FRONT: pc = PC_PUSH_F;
         FN_PUSH_BACK:  pc = PC_PUSH_B;
         FN_POP_FRONT:  pc = PC_POP_F;
         FN_POP_BACK:   pc = PC_POP_B;
         FN_DELETE:     pc = PC_SCAN_RD;
         default:       pc = PC_MISS;
      endcase
      return pc;
   endfunction

   // control store
   function automatic uword_type ucode(input logic [PcW-1:0] pc);
      uword_type uw;
      uw = UW_NOP;
      case (pc)
         PC_PUSH_F: begin
            uw.cond   = COND_FULL;
            uw.target = PC_REFUSE;
         end
         PC_PUSH_F_WR: begin
            uw.we       = 1'b1;
            uw.wa       = WA_FRONT_M1;
            uw.wd       = WD_VALUE;
            uw.front_op = FR_DEC;
            uw.cnt_op   = CNT_INC;
            uw.last     = 1'b1;
         end
         PC_PUSH_B: begin
            uw.cond   = COND_FULL;
            uw.target = PC_REFUSE;
         end
         PC_PUSH_B_WR: begin
            uw.we     = 1'b1;
            uw.wa     = WA_BACK;
            uw.wd     = WD_VALUE;
            uw.cnt_op = CNT_INC;
            uw.last   = 1'b1;
         end
         PC_POP_F: begin
            uw.cond   = COND_EMPTY;
            uw.target = PC_MISS;
         end
         PC_POP_F_UPD: begin
            uw.front_op = FR_INC;
            uw.cnt_op   = CNT_DEC;
            uw.last     = 1'b1;
         end
         PC_POP_B: begin
            uw.cond   = COND_EMPTY;
            uw.target = PC_MISS;
         end
         PC_POP_B_UPD: begin
            uw.cnt_op = CNT_DEC;
            uw.last   = 1'b1;
         end
         PC_SCAN_RD: begin
            uw.cond   = COND_KEND;
            uw.target = PC_MISS;
            uw.ra     = RA_K;
         end
         PC_SCAN_CMP: begin
            // no match: step on and read the next entry
            uw.cond   = COND_NOMATCH;
            uw.target = PC_SCAN_RD;
            uw.k_op   = K_INC_TK;
         end
         PC_SHIFT_RD: begin
            uw.cond   = COND_K1END;
            uw.target = PC_DEL;
            uw.ra     = RA_K1;
         end
         PC_SHIFT_WR: begin
            uw.cond   = COND_ALWAYS;
            uw.target = PC_SHIFT_RD;
            uw.we     = 1'b1;
            uw.wa     = WA_K;
            uw.wd     = WD_RDATA;
            uw.k_op   = K_INC;
         end
         PC_DEL: begin
            uw.cnt_op = CNT_DEC;
            uw.last   = 1'b1;
         end
         PC_REFUSE: begin
            uw.status = ST_FULL;
            uw.last   = 1'b1;
         end
         default: begin
            uw.status = ST_MISS;
            uw.last   = 1'b1;
         end
      endcase
      return uw;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ddq_ram.sv =====
// ----------------------------------------------------------------------------
// ddq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddq_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/deque_with_delete_by_value_core.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_core
// Bounded double-ended queue of signed 32-bit values with delete of the first
// matching entry, run by a small microprogram over a ring buffer in RAM.
// ----------------------------------------------------------------------------
//  channel   ports                              transfer when
//  request   start, busy, req_func, req_value   start high and busy low
//  response  rsp_strobe, rsp_status, rsp_count  rsp_strobe high (one cycle)
//
// push and pop run a check step, then an update or a refusal step; delete walks
// all n entries on a hit and on a miss alike, two steps per entry, set by the
// single read port of the entry RAM and its registered read.
// a new request is taken in the same cycle its predecessor's response shows.
// reset clears the front position and count; the RAM is never cleared.
// the response side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_value_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ddq_pkg::FuncW-1:0]     req_func,
   input  wire logic signed [ddq_pkg::DataW-1:0] req_value,
   output logic                               rsp_strobe,
   output logic      [ddq_pkg::StatW-1:0]     rsp_status,
   output logic      [ddq_pkg::CntW-1:0]      rsp_count
);

   localparam int AW = ddq_pkg::AddrW;
   localparam int CW = ddq_pkg::CntW;
   localparam int DW = ddq_pkg::DataW;

   logic                           busy_ff;
   logic [ddq_pkg::PcW-1:0]        upc_ff;
   logic [ddq_pkg::PcW-1:0]        upc_in;
   logic [AW-1:0]                  front_ff;
   logic [AW-1:0]                  front_in;
   logic [CW-1:0]                  cnt_ff;
   logic [CW-1:0]                  cnt_in;
   logic [CW-1:0]                  k_ff;
   logic [CW-1:0]                  k_in;
   logic [DW-1:0]                  value_ff;
   logic                           rsp_strobe_ff;
   logic [ddq_pkg::StatW-1:0]      rsp_status_ff;
   logic [CW-1:0]                  rsp_count_ff;

   ddq_pkg::uword_type             uw;
   logic                           taken;
   logic [CW:0]                    k_p1;
   logic [AW-1:0]                  front_m1;
   logic [AW-1:0]                  front_p1;
   logic [AW-1:0]                  rd_addr;
   logic [AW-1:0]                  wr_addr;
   logic [DW-1:0]                  wr_data;
   logic [DW-1:0]                  rd_data;
   logic                           wr_en;
   logic                           accept;

   assign accept = start && !busy_ff;
   assign uw     = ddq_pkg::ucode(upc_ff);
   assign k_p1   = {1'b0, k_ff} + (CW + 1)'(1);

   assign front_m1 = (front_ff == '0) ? AW'(ddq_pkg::DEPTH - 1) : front_ff - AW'(1);
   assign front_p1 = (front_ff == AW'(ddq_pkg::DEPTH - 1)) ? '0 : front_ff + AW'(1);

   // branch condition
   always_comb begin
      case (uw.cond)
         ddq_pkg::COND_NEXT:    taken = 1'b0;
         ddq_pkg::COND_ALWAYS:  taken = 1'b1;
         ddq_pkg::COND_FULL:    taken = (cnt_ff == CW'(ddq_pkg::DEPTH));
         ddq_pkg::COND_EMPTY:   taken = (cnt_ff == '0);
         ddq_pkg::COND_KEND:    taken = (k_ff >= cnt_ff);
         ddq_pkg::COND_K1END:   taken = (k_p1 >= {1'b0, cnt_ff});
         ddq_pkg::COND_NOMATCH: taken = (rd_data != value_ff);
         default:               taken = 1'b0;
      endcase
   end

   assign upc_in = taken ? uw.target : upc_ff + ddq_pkg::PcW'(1);

   always_comb begin
      case (uw.k_op)
         ddq_pkg::K_INC:    k_in = k_p1[CW-1:0];
         ddq_pkg::K_INC_TK: k_in = taken ? k_p1[CW-1:0] : k_ff;
         default:           k_in = k_ff;
      endcase
   end

   always_comb begin
      case (uw.cnt_op)
         ddq_pkg::CNT_INC: cnt_in = cnt_ff + CW'(1);
         ddq_pkg::CNT_DEC: cnt_in = cnt_ff - CW'(1);
         default:          cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      case (uw.front_op)
         ddq_pkg::FR_INC: front_in = front_p1;
         ddq_pkg::FR_DEC: front_in = front_m1;
         default:         front_in = front_ff;
      endcase
   end

   // entry RAM addressing
   assign rd_addr = (uw.ra == ddq_pkg::RA_K1) ? ddq_pkg::ring_pos(front_ff, k_p1[CW-1:0])
                                              : ddq_pkg::ring_pos(front_ff, k_ff);

   always_comb begin
      case (uw.wa)
         ddq_pkg::WA_FRONT_M1: wr_addr = front_m1;
         ddq_pkg::WA_BACK:     wr_addr = ddq_pkg::ring_pos(front_ff, cnt_ff);
         default:              wr_addr = ddq_pkg::ring_pos(front_ff, k_ff);
      endcase
   end

   assign wr_data = (uw.wd == ddq_pkg::WD_RDATA) ? rd_data : value_ff;
   assign wr_en   = busy_ff && uw.we;

   ddq_ram #(
      .Width (DW),
      .Depth (ddq_pkg::DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         upc_ff        <= ddq_pkg::PC_MISS;
         front_ff      <= '0;
         cnt_ff        <= '0;
         k_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= ddq_pkg::ST_DONE;
         rsp_count_ff  <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (accept) begin
            busy_ff  <= 1'b1;
            upc_ff   <= ddq_pkg::entry_pc(req_func);
            value_ff <= req_value;
            k_ff     <= '0;
         end else if (busy_ff) begin
            upc_ff   <= upc_in;
            k_ff     <= k_in;
            cnt_ff   <= cnt_in;
            front_ff <= front_in;
            if (uw.last) begin
               busy_ff       <= 1'b0;
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= uw.status;
               rsp_count_ff  <= cnt_in;
            end
         end
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire
